FILE: sv/length_framed_crc32_checker_macros.svh
// Assertion helpers for the RTL (included by lfcc_out_reg.sv).
`ifndef LENGTH_FRAMED_CRC32_CHECKER_MACROS_SVH
`define LENGTH_FRAMED_CRC32_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LFCC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LFCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lfcc_pkg.sv
`default_nettype none

package lfcc_pkg;

    // Reflected CRC-32 (IEEE 802.3)
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Defaults for top-level parameters and the config register
    localparam int          LENGTH_BYTES_DEFAULT = 4;
    localparam logic [31:0] MAX_LEN_RESET        = 32'd65536;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] frame_length;
        logic [31:0] computed_crc;
    } result_t;

    // One byte through the bitwise CRC update
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: sv/length_framed_crc32_checker.sv
// The result of the byte that ends the frame (last length byte for a bad length,
//   last trailer byte otherwise) is registered on m_* or, if m_* is stalled, in the skid entry.
// Throughput: one byte per cycle; s_ready drops only while two results wait
//   at the output (output register plus one skid entry).
// Reset (aresetn low, synchronous): no frame open, output empty,
//   max_frame_length back to 65536.
`default_nettype none

module length_framed_crc32_checker #(
    parameter int LENGTH_BYTES = lfcc_pkg::LENGTH_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_start,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_frame_length,
    output logic [31:0]      m_computed_crc,
    // max_frame_length register write
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);

    logic              byte_accept;
    logic              res_valid;
    lfcc_pkg::result_t res;
    lfcc_pkg::result_t m_res;

    // A transaction on the byte channel
    assign byte_accept = s_valid && s_ready;

    lfcc_frame_core #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .data_byte   (s_data_byte),
        .frame_start (s_frame_start),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    lfcc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_res)
    );

    assign m_status       = m_res.status;
    assign m_frame_length = m_res.frame_length;
    assign m_computed_crc = m_res.computed_crc;

endmodule

`default_nettype wire

FILE: sv/lfcc_frame_core.sv
`default_nettype none

// Frame tracking: header length capture, CRC update, trailer capture and
// the end-of-frame decision, all done on the accepted byte.
module lfcc_frame_core #(
    parameter int LENGTH_BYTES = lfcc_pkg::LENGTH_BYTES_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              frame_start,
    input  wire logic              cfg_wr_en,
    input  wire logic [31:0]       cfg_wr_data,
    output logic                   res_valid,
    output lfcc_pkg::result_t      res
);

    localparam int LW      = 8 * LENGTH_BYTES;
    localparam int CW      = $clog2(LENGTH_BYTES + 1);
    localparam int MIN_LEN = (LENGTH_BYTES + 4 > 8) ? (LENGTH_BYTES + 4) : 8;

    logic [31:0]   max_len_reg;
    logic          in_frame_reg,  in_frame_next;
    logic [CW-1:0] hdr_cnt_reg,   hdr_cnt_next;
    logic [LW-1:0] length_reg,    length_next;
    logic [31:0]   crc_reg,       crc_next;
    logic [31:0]   trailer_reg,   trailer_next;
    logic [31:0]   left_reg,      left_next;

    // State as seen by this byte (a frame start restarts everything)
    logic          active;
    logic [CW-1:0] hdr_cnt_eff;
    logic [LW-1:0] length_eff;
    logic [31:0]   crc_eff;
    logic [31:0]   crc_upd;
    logic [LW+31:0] len_new_ext;
    logic [LW+31:0] len_old_ext;
    logic [LW+31:0] max_ext;
    logic [31:0]   crc_final;

    assign active      = frame_start || in_frame_reg;
    assign hdr_cnt_eff = frame_start ? '0 : hdr_cnt_reg;
    assign length_eff  = frame_start ? '0 : length_reg;
    assign crc_eff     = frame_start ? lfcc_pkg::CRC_ALL_ONES : crc_reg;
    assign crc_upd     = lfcc_pkg::crc_byte(crc_eff, data_byte);
    assign len_new_ext = {32'd0, length_next};
    assign len_old_ext = {32'd0, length_reg};
    assign max_ext     = {{LW{1'b0}}, max_len_reg};
    assign crc_final   = crc_reg ^ lfcc_pkg::CRC_ALL_ONES;

    // Next state and result
    always_comb begin
        in_frame_next = in_frame_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        length_next   = length_eff;
        crc_next      = crc_reg;
        trailer_next  = trailer_reg;
        left_next     = left_reg;
        res_valid     = 1'b0;
        res           = '{status: lfcc_pkg::STATUS_OK, frame_length: 32'd0,
                          computed_crc: 32'd0};

        // length byte insert, little-endian
        for (int i = 0; i < LENGTH_BYTES; i++) begin
            if (hdr_cnt_eff == CW'(i)) begin
                length_next[8*i +: 8] = data_byte;
            end
        end

        if (active) begin
            in_frame_next = 1'b1;
            if (hdr_cnt_eff < CW'(LENGTH_BYTES)) begin
                // header byte
                crc_next     = crc_upd;
                hdr_cnt_next = hdr_cnt_eff + CW'(1);
                left_next    = len_new_ext[31:0] - 32'(LENGTH_BYTES);
                if (hdr_cnt_eff == CW'(LENGTH_BYTES - 1)) begin
                    if ((len_new_ext < (LW+32)'(MIN_LEN)) || (len_new_ext > max_ext)) begin
                        in_frame_next    = 1'b0;
                        res_valid        = 1'b1;
                        res.status       = lfcc_pkg::STATUS_BAD_LEN;
                        res.frame_length = len_new_ext[31:0];
                    end
                end
            end else begin
                // body or trailer byte
                left_next = left_reg - 32'd1;
                if (left_reg > 32'd4) begin
                    crc_next = crc_upd;
                end else begin
                    trailer_next = {data_byte, trailer_reg[31:8]};
                end
                if (left_reg == 32'd1) begin
                    in_frame_next    = 1'b0;
                    res_valid        = 1'b1;
                    res.status       = (crc_final == trailer_next) ?
                                       lfcc_pkg::STATUS_OK : lfcc_pkg::STATUS_CRC_ERR;
                    res.frame_length = len_old_ext[31:0];
                    res.computed_crc = crc_final;
                end
            end
        end
        if (!byte_accept) begin
            res_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            hdr_cnt_reg  <= '0;
            max_len_reg  <= lfcc_pkg::MAX_LEN_RESET;
        end else begin
            if (byte_accept) begin
                in_frame_reg <= in_frame_next;
                hdr_cnt_reg  <= hdr_cnt_next;
            end
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    // Frame datapath
    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            length_reg  <= length_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
            left_reg    <= left_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lfcc_out_reg.sv
`default_nettype none
`include "length_framed_crc32_checker_macros.svh"

// Result output register with one skid entry behind it.
module lfcc_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire lfcc_pkg::result_t push_data,
    output logic                   in_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lfcc_pkg::result_t      m_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    lfcc_pkg::result_t main_reg,       main_next;
    lfcc_pkg::result_t skid_reg,       skid_next;
    logic              pop;

    assign pop      = main_valid_reg && m_ready;
    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    // Occupancy and data movement
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `LFCC_ASSERT_NOW(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg, "skid entry held without an output entry")
    `LFCC_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, push && main_valid_reg && !m_ready, skid_valid_reg, "stalled result was not kept in the skid entry")
    `LFCC_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_ready, main_valid_reg && !skid_valid_reg, "skid entry did not move to the output")

endmodule

`default_nettype wire
